>>> rtl/core/ler_pkg.sv
// shared types, codes and constants of the line edit receiver
package ler_pkg;

    // character codes handled by the line editor
    localparam logic [7:0] CH_EOT   = 8'h04;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // configuration register reset values
    localparam logic [31:0] WINDOW_BASE_RST  = 32'hA000_0000;
    localparam logic [31:0] WINDOW_LIMIT_RST = 32'hA400_0000;

    // command queue between front and back
    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    // configuration register index
    typedef enum logic {
        REG_WINDOW_BASE  = 1'b0,
        REG_WINDOW_LIMIT = 1'b1
    } t_reg;

    // result kind
    typedef enum logic [1:0] {
        KIND_ECHO  = 2'd0,
        KIND_STORE = 2'd1,
        KIND_DONE  = 2'd2
    } t_kind;

    // completion status
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_FILE = 2'd1,
        ST_BAD_ADDR = 2'd2
    } t_status;

    // command classes produced by the front
    typedef enum logic [1:0] {
        OP_DONE    = 2'd0,
        OP_ERASE   = 2'd1,
        OP_NEWLINE = 2'd2,
        OP_CHAR    = 2'd3
    } t_op;

    // one classified item waiting for the back
    typedef struct packed {
        t_op         op;
        logic [7:0]  chr;
        logic [31:0] addr;
        logic [31:0] count;
        t_status     status;
        logic        fin;
    } t_cmd;

    // one result item
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [31:0] addr;
        t_status     status;
        logic [31:0] count;
        logic        last;
    } t_result;

endpackage

>>> rtl/core/ler_front.sv
// front: accepts items, keeps the request state and classifies each item into a command
module ler_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_func,
    input  logic [7:0]      i_file_number,
    input  logic [31:0]     i_buffer_address,
    input  logic [31:0]     i_byte_limit,
    input  logic [7:0]      i_char_in,
    input  logic [31:0]     i_window_base,
    input  logic [31:0]     i_window_limit,
    output logic            o_cmd_push,
    output ler_pkg::t_cmd   o_cmd
);

    logic        r_busy;
    logic [31:0] r_line_start;
    logic [31:0] r_stored_length;
    logic [31:0] r_request_limit;

    logic        n_busy;
    logic [31:0] n_line_start;
    logic [31:0] n_stored_length;
    logic [31:0] n_request_limit;

    logic [31:0] at_addr;
    logic [31:0] len_inc;
    logic [32:0] end_sum;
    logic        bad_addr;

    // address of the next byte of the line and the grown length
    assign at_addr = r_line_start + r_stored_length;
    assign len_inc = r_stored_length + 32'd1;

    // buffer window check, end computed without wrap
    assign end_sum  = {1'b0, i_buffer_address} + {1'b0, i_byte_limit};
    assign bad_addr = (i_buffer_address < i_window_base) ||
                      (end_sum > {1'b0, i_window_limit});

    // classification and next request state
    always_comb begin
        n_busy          = r_busy;
        n_line_start    = r_line_start;
        n_stored_length = r_stored_length;
        n_request_limit = r_request_limit;
        o_cmd_push      = 1'b0;
        o_cmd           = '0;
        if (i_accept) begin
            if (!i_func) begin
                n_busy      = 1'b0;
                o_cmd.op    = ler_pkg::OP_DONE;
                if (i_file_number != 8'd0) begin
                    o_cmd_push   = 1'b1;
                    o_cmd.status = ler_pkg::ST_BAD_FILE;
                end else if (bad_addr) begin
                    o_cmd_push   = 1'b1;
                    o_cmd.status = ler_pkg::ST_BAD_ADDR;
                end else if (i_byte_limit == 32'd0) begin
                    o_cmd_push   = 1'b1;
                    o_cmd.status = ler_pkg::ST_OK;
                end else begin
                    n_busy          = 1'b1;
                    n_line_start    = i_buffer_address;
                    n_stored_length = 32'd0;
                    n_request_limit = i_byte_limit;
                end
            end else if (r_busy) begin
                case (i_char_in) inside
                    ler_pkg::CH_EOT: begin
                        o_cmd_push  = 1'b1;
                        o_cmd.op    = ler_pkg::OP_DONE;
                        o_cmd.count = r_stored_length;
                        n_busy      = 1'b0;
                    end
                    ler_pkg::CH_BS, ler_pkg::CH_DEL: begin
                        // erase only when something is stored
                        if (r_stored_length != 32'd0) begin
                            o_cmd_push      = 1'b1;
                            o_cmd.op        = ler_pkg::OP_ERASE;
                            n_stored_length = r_stored_length - 32'd1;
                        end
                    end
                    ler_pkg::CH_LF, ler_pkg::CH_CR: begin
                        o_cmd_push  = 1'b1;
                        o_cmd.op    = ler_pkg::OP_NEWLINE;
                        o_cmd.addr  = at_addr;
                        o_cmd.count = len_inc;
                        n_busy      = 1'b0;
                    end
                    default: begin
                        o_cmd_push      = 1'b1;
                        o_cmd.op        = ler_pkg::OP_CHAR;
                        o_cmd.chr       = i_char_in;
                        o_cmd.addr      = at_addr;
                        o_cmd.count     = r_request_limit;
                        o_cmd.fin       = (len_inc >= r_request_limit);
                        n_stored_length = len_inc;
                        if (len_inc >= r_request_limit) begin
                            n_busy = 1'b0;
                        end
                    end
                endcase
            end
        end
    end

    // request state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy          <= 1'b0;
            r_line_start    <= 32'd0;
            r_stored_length <= 32'd0;
            r_request_limit <= 32'd0;
        end else begin
            r_busy          <= n_busy;
            r_line_start    <= n_line_start;
            r_stored_length <= n_stored_length;
            r_request_limit <= n_request_limit;
        end
    end

endmodule

>>> rtl/core/ler_cmd_fifo.sv
// short command queue between front and back
module ler_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ler_pkg::t_cmd   i_data,
    input  logic            i_pop,
    output ler_pkg::t_cmd   o_data,
    output logic            o_full,
    output logic            o_empty
);

    ler_pkg::t_cmd                    r_mem [ler_pkg::CMD_DEPTH];
    logic [ler_pkg::CMD_PTR_W-1:0]    r_wr_ptr;
    logic [ler_pkg::CMD_PTR_W-1:0]    r_rd_ptr;
    logic [ler_pkg::CMD_CNT_W-1:0]    r_count;

    logic [ler_pkg::CMD_CNT_W-1:0]    n_count;
    logic                             do_push;
    logic                             do_pop;

    assign o_full  = (r_count == ler_pkg::CMD_CNT_W'(ler_pkg::CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> rtl/core/ler_back.sv
// back: feeds each command's result items to the output register, one per cycle unless held
module ler_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  ler_pkg::t_cmd     i_cmd,
    output logic              o_cmd_pop,
    input  logic              i_pop,
    output logic              o_valid,
    output ler_pkg::t_result  o_res
);

    logic [1:0]        r_step;
    logic              r_valid;
    ler_pkg::t_result  r_res;

    logic [1:0]        n_step;
    ler_pkg::t_result  res;
    logic              adv;

    // result item for the current step of the head command
    always_comb begin
        res = '0;
        case (i_cmd.op)
            ler_pkg::OP_DONE: begin
                res.kind   = ler_pkg::KIND_DONE;
                res.status = i_cmd.status;
                res.count  = i_cmd.count;
                res.last   = 1'b1;
            end
            ler_pkg::OP_ERASE: begin
                // backspace, space, backspace
                res.kind = ler_pkg::KIND_ECHO;
                res.data = (r_step == 2'd1) ? ler_pkg::CH_SPACE : ler_pkg::CH_BS;
                res.last = (r_step == 2'd2);
            end
            ler_pkg::OP_NEWLINE: begin
                case (r_step)
                    2'd0: begin
                        res.kind = ler_pkg::KIND_STORE;
                        res.data = ler_pkg::CH_LF;
                        res.addr = i_cmd.addr;
                    end
                    2'd1: begin
                        res.kind = ler_pkg::KIND_STORE;
                        res.data = ler_pkg::CH_NUL;
                        res.addr = i_cmd.addr + 32'd1;
                    end
                    2'd2: begin
                        res.kind = ler_pkg::KIND_ECHO;
                        res.data = ler_pkg::CH_LF;
                    end
                    default: begin
                        res.kind  = ler_pkg::KIND_DONE;
                        res.count = i_cmd.count;
                        res.last  = 1'b1;
                    end
                endcase
            end
            default: begin
                // plain character: echo, store, done when the limit is hit
                case (r_step)
                    2'd0: begin
                        res.kind = ler_pkg::KIND_ECHO;
                        res.data = i_cmd.chr;
                    end
                    2'd1: begin
                        res.kind = ler_pkg::KIND_STORE;
                        res.data = i_cmd.chr;
                        res.addr = i_cmd.addr;
                        res.last = !i_cmd.fin;
                    end
                    default: begin
                        res.kind  = ler_pkg::KIND_DONE;
                        res.count = i_cmd.count;
                        res.last  = 1'b1;
                    end
                endcase
            end
        endcase
    end

    // move one item when the output register is free or being drained
    assign adv       = i_cmd_valid && (!r_valid || i_pop);
    assign o_cmd_pop = adv && res.last;
    assign n_step    = res.last ? 2'd0 : r_step + 2'd1;

    // step counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 2'd0;
            r_valid <= 1'b0;
        end else if (adv) begin
            r_step  <= n_step;
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

>>> rtl/core/line_edit_receiver_top.sv
// top level of the line edit receiver: configuration registers, front, command queue, back
//
// Input items enter through push/full: func 0 opens a read request, func 1 brings one
// received character. Results leave through empty/pop, oldest first: echo bytes, store
// bytes with their address, and a done item with status and count; last marks the final
// result of an input item. window_base and window_limit sit on the APB port at 0x0 and 0x4.
// The front classifies an item in the cycle it is accepted and updates the request state,
// so a new item can be taken every cycle while the command queue has room. The back emits
// one result per cycle from the queue head while the output register is free or popped;
// an item gives one to four results, which set the sustained rate when results are dense.
// An accepted item is written to the command queue, then moved into the output register.
// A stalled receiver holds the output register, the back stops, the two-entry queue fills
// and full rises; items that give no result still need a free queue slot to be taken.
// Reset clears the request state, the queue and the output register and loads the window
// registers with their defaults; empty is high after reset.
module line_edit_receiver_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // item input queue side
    input  logic         push,
    output logic         full,
    input  logic         i_func,
    input  logic [7:0]   i_file_number,
    input  logic [31:0]  i_buffer_address,
    input  logic [31:0]  i_byte_limit,
    input  logic [7:0]   i_char_in,
    // result queue side
    output logic         empty,
    input  logic         pop,
    output logic [1:0]   o_kind,
    output logic [7:0]   o_out_byte,
    output logic [31:0]  o_store_address,
    output logic [1:0]   o_status,
    output logic [31:0]  o_byte_count,
    output logic         o_last,
    // configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [31:0]       r_window_base;
    logic [31:0]       r_window_limit;

    logic              cfg_wr;
    ler_pkg::t_reg     cfg_sel;
    logic              in_accept;
    logic              cmd_push;
    ler_pkg::t_cmd     cmd_in;
    ler_pkg::t_cmd     cmd_head;
    logic              cmd_full;
    logic              cmd_empty;
    logic              cmd_pop;
    logic              res_valid;
    ler_pkg::t_result  res;

    // configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = ler_pkg::t_reg'(paddr[2]);
    assign prdata  = (cfg_sel == ler_pkg::REG_WINDOW_LIMIT) ? r_window_limit : r_window_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_base  <= ler_pkg::WINDOW_BASE_RST;
            r_window_limit <= ler_pkg::WINDOW_LIMIT_RST;
        end else if (cfg_wr) begin
            if (cfg_sel == ler_pkg::REG_WINDOW_LIMIT) begin
                r_window_limit <= pwdata;
            end else begin
                r_window_base <= pwdata;
            end
        end
    end

    // input handshake
    assign full      = cmd_full;
    assign in_accept = push && !full;

    // front
    ler_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_func           (i_func),
        .i_file_number    (i_file_number),
        .i_buffer_address (i_buffer_address),
        .i_byte_limit     (i_byte_limit),
        .i_char_in        (i_char_in),
        .i_window_base    (r_window_base),
        .i_window_limit   (r_window_limit),
        .o_cmd_push       (cmd_push),
        .o_cmd            (cmd_in)
    );

    // command queue
    ler_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .i_pop   (cmd_pop),
        .o_data  (cmd_head),
        .o_full  (cmd_full),
        .o_empty (cmd_empty)
    );

    // back
    ler_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_valid     (res_valid),
        .o_res       (res)
    );

    // result ports
    assign empty           = !res_valid;
    assign o_kind          = res.kind;
    assign o_out_byte      = res.data;
    assign o_store_address = res.addr;
    assign o_status        = res.status;
    assign o_byte_count    = res.count;
    assign o_last          = res.last;

    // output queue is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // a done item always closes the results of its input item
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == ler_pkg::KIND_DONE) |-> o_last)
        else $error("done item without last");

    // error completions carry no count
    a_err_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ler_pkg::ST_OK) |->
            (o_kind == ler_pkg::KIND_DONE && o_byte_count == 32'd0))
        else $error("error status on a non-done item or with a count");

    // the front never writes a full command queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push |-> !cmd_full)
        else $error("command pushed into a full queue");

endmodule

>>> bench/line_edit_receiver_top_tb.sv
// self-checking bench for the line edit receiver: directed rows, random line sessions, window changes
module line_edit_receiver_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ler_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RST_CYCLES   = 5;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 25;
    localparam int N_PHASES     = 6;
    localparam int N_ROWS       = 25;

    // window settings per phase, the first one is the reset value
    localparam logic [31:0] PH_BASE [N_PHASES] = '{
        32'hA000_0000, 32'h0000_0000, 32'hFFFF_FFF0,
        32'h0000_0000, 32'h0000_1000, 32'h8000_0000
    };
    localparam logic [31:0] PH_LIMIT [N_PHASES] = '{
        32'hA400_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'h0000_0000, 32'h0000_1100, 32'h0000_0010
    };

    // how a directed row is checked
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_DONE
    } t_check;

    typedef struct {
        bit          func;
        logic [7:0]  fd;
        logic [31:0] addr;
        logic [31:0] lim;
        logic [7:0]  chr;
        t_check      chk;
        t_status     st;
        logic [31:0] cnt;
    } t_row;

    // directed rows under the reset window 0xA0000000 .. 0xA4000000
    t_row dir_rows [N_ROWS] = '{
        '{1'b1, 8'h00, 32'h0,         32'h0,         8'h41,    CHK_NONE,  ST_OK,       32'h0},
        '{1'b0, 8'hFF, 32'hA000_0000, 32'h1,         8'h00,    CHK_DONE,  ST_BAD_FILE, 32'h0},
        '{1'b0, 8'h01, 32'hA000_0000, 32'h1,         8'h00,    CHK_DONE,  ST_BAD_FILE, 32'h0},
        '{1'b0, 8'h00, 32'h9FFF_FFFF, 32'h1,         8'h00,    CHK_DONE,  ST_BAD_ADDR, 32'h0},
        '{1'b0, 8'h00, 32'hA000_0000, 32'h0400_0001, 8'h00,    CHK_DONE,  ST_BAD_ADDR, 32'h0},
        '{1'b0, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00,    CHK_DONE,  ST_BAD_ADDR, 32'h0},
        '{1'b0, 8'h00, 32'hA000_0000, 32'h0,         8'h00,    CHK_DONE,  ST_OK,       32'h0},
        '{1'b0, 8'h00, 32'hA3FF_FFFF, 32'h1,         8'h00,    CHK_NONE,  ST_OK,       32'h0},
        '{1'b1, 8'h00, 32'h0,         32'h0,         8'h00,    CHK_MODEL, ST_OK,       32'h0},
        '{1'b0, 8'h00, 32'hA000_0000, 32'h0400_0000, 8'h00,    CHK_NONE,  ST_OK,       32'h0},
        '{1'b1, 8'h00, 32'h0,         32'h0,         CH_BS,    CHK_NONE,  ST_OK,       32'h0},
        '{1'b1, 8'h00, 32'h0,         32'h0,         8'h68,    CHK_MODEL, ST_OK,       32'h0},
        '{1'b1, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,    CHK_MODEL, ST_OK,       32'h0},
        '{1'b1, 8'h00, 32'h0,         32'h0,         CH_DEL,   CHK_MODEL, ST_OK,       32'h0},
        '{1'b1, 8'h00, 32'h0,         32'h0,         CH_BS,    CHK_MODEL, ST_OK,       32'h0},
        '{1'b1, 8'h00, 32'h0,         32'h0,         CH_BS,    CHK_MODEL, ST_OK,       32'h0},
        '{1'b1, 8'h00, 32'h0,         32'h0,         8'h78,    CHK_MODEL, ST_OK,       32'h0},
        '{1'b1, 8'h00, 32'h0,         32'h0,         CH_CR,    CHK_MODEL, ST_OK,       32'h0},
        '{1'b0, 8'h00, 32'hA000_1000, 32'h8,         8'h00,    CHK_NONE,  ST_OK,       32'h0},
        '{1'b1, 8'h00, 32'h0,         32'h0,         8'h61,    CHK_MODEL, ST_OK,       32'h0},
        '{1'b0, 8'h00, 32'hA000_2000, 32'h3,         8'h00,    CHK_NONE,  ST_OK,       32'h0},
        '{1'b1, 8'h00, 32'h0,         32'h0,         8'h62,    CHK_MODEL, ST_OK,       32'h0},
        '{1'b1, 8'h00, 32'h0,         32'h0,         CH_LF,    CHK_MODEL, ST_OK,       32'h0},
        '{1'b0, 8'h00, 32'hA000_3000, 32'h5,         8'h00,    CHK_NONE,  ST_OK,       32'h0},
        '{1'b1, 8'h00, 32'h0,         32'h0,         CH_EOT,   CHK_DONE,  ST_OK,       32'h0}
    };

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        push             = 1'b0;
    logic        full;
    logic        i_func           = 1'b0;
    logic [7:0]  i_file_number    = '0;
    logic [31:0] i_buffer_address = '0;
    logic [31:0] i_byte_limit     = '0;
    logic [7:0]  i_char_in        = '0;
    logic        empty;
    logic        pop              = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_out_byte;
    logic [31:0] o_store_address;
    logic [1:0]  o_status;
    logic [31:0] o_byte_count;
    logic        o_last;
    logic        psel             = 1'b0;
    logic        penable          = 1'b0;
    logic        pwrite           = 1'b0;
    logic [2:0]  paddr            = '0;
    logic [31:0] pwdata           = '0;
    logic [31:0] prdata;
    logic        pready;

    // line editor state as the bench sees it
    logic [31:0] win_base  = WINDOW_BASE_RST;
    logic [31:0] win_limit = WINDOW_LIMIT_RST;
    bit          line_busy = 1'b0;
    logic [31:0] line_base = '0;
    logic [31:0] line_len  = '0;
    logic [31:0] line_cap  = '0;

    t_result step_results [$];
    t_result pending_results [$];

    int errors        = 0;
    int items_taken   = 0;
    int results_seen  = 0;
    int push_run      = 0;
    int pop_run       = 0;

    line_edit_receiver_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_func           (i_func),
        .i_file_number    (i_file_number),
        .i_buffer_address (i_buffer_address),
        .i_byte_limit     (i_byte_limit),
        .i_char_in        (i_char_in),
        .empty            (empty),
        .pop              (pop),
        .o_kind           (o_kind),
        .o_out_byte       (o_out_byte),
        .o_store_address  (o_store_address),
        .o_status         (o_status),
        .o_byte_count     (o_byte_count),
        .o_last           (o_last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // clock
    always #(CLK_HALF) i_clk = ~i_clk;

    // append one result to the current item's list
    function automatic void add_res(t_kind k, logic [7:0] d, logic [31:0] a, t_status s,
                                    logic [31:0] n);
        t_result r;
        r.kind   = k;
        r.data   = d;
        r.addr   = a;
        r.status = s;
        r.count  = n;
        r.last   = 1'b0;
        step_results.push_back(r);
    endfunction

    // line editing of one accepted item, results land in step_results
    function automatic void edit_line(bit f, logic [7:0] fd, logic [31:0] a, logic [31:0] l,
                                      logic [7:0] c);
        logic [31:0] slot;
        t_result     r;
        step_results.delete();
        slot = line_base + line_len;
        if (!f) begin
            line_busy = 1'b0;
            if (fd != 8'h00) begin
                add_res(KIND_DONE, CH_NUL, '0, ST_BAD_FILE, '0);
            end else if (a < win_base || ({32'h0, a} + {32'h0, l}) > {32'h0, win_limit}) begin
                add_res(KIND_DONE, CH_NUL, '0, ST_BAD_ADDR, '0);
            end else if (l == '0) begin
                add_res(KIND_DONE, CH_NUL, '0, ST_OK, '0);
            end else begin
                line_busy = 1'b1;
                line_base = a;
                line_len  = '0;
                line_cap  = l;
            end
        end else if (line_busy) begin
            case (c)
                CH_EOT: begin
                    add_res(KIND_DONE, CH_NUL, '0, ST_OK, line_len);
                    line_busy = 1'b0;
                end
                CH_BS, CH_DEL: begin
                    // erase echo only when a byte was really removed
                    if (line_len != '0) begin
                        line_len = line_len - 1;
                        add_res(KIND_ECHO, CH_BS, '0, ST_OK, '0);
                        add_res(KIND_ECHO, CH_SPACE, '0, ST_OK, '0);
                        add_res(KIND_ECHO, CH_BS, '0, ST_OK, '0);
                    end
                end
                CH_LF, CH_CR: begin
                    add_res(KIND_STORE, CH_LF, slot, ST_OK, '0);
                    add_res(KIND_STORE, CH_NUL, slot + 1, ST_OK, '0);
                    add_res(KIND_ECHO, CH_LF, '0, ST_OK, '0);
                    add_res(KIND_DONE, CH_NUL, '0, ST_OK, line_len + 1);
                    line_busy = 1'b0;
                end
                default: begin
                    add_res(KIND_ECHO, c, '0, ST_OK, '0);
                    add_res(KIND_STORE, c, slot, ST_OK, '0);
                    line_len = line_len + 1;
                    if (line_len >= line_cap) begin
                        add_res(KIND_DONE, CH_NUL, '0, ST_OK, line_cap);
                        line_busy = 1'b0;
                    end
                end
            endcase
        end
        if (step_results.size() > 0) begin
            r = step_results[$];
            r.last = 1'b1;
            step_results[step_results.size() - 1] = r;
        end
    endfunction

    // idle cycles before an item, with runs of back-to-back items
    function automatic int draw_gap(inout int run);
        if (run > 0) begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            run = $urandom_range(5, 30);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    // received character, weighted towards the editing keys
    function automatic logic [7:0] pick_char();
        int q;
        q = $urandom_range(0, 99);
        if (q < 8)  return CH_BS;
        if (q < 12) return CH_DEL;
        if (q < 15) return CH_EOT;
        if (q < 19) return CH_LF;
        if (q < 22) return CH_CR;
        if (q < 60) return 8'($urandom_range(8'h20, 8'h7e));
        return 8'($urandom);
    endfunction

    function automatic void check_field(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
        end
    endfunction

    // drive one item, wait for it to be taken, then queue what it should give
    task automatic send_item(input bit f, input logic [7:0] fd, input logic [31:0] a,
                             input logic [31:0] l, input logic [7:0] c, input t_check chk,
                             input t_status st, input logic [31:0] cnt, output bit ign);
        int      gap;
        t_result r;
        gap = draw_gap(push_run);
        if (gap > 0) begin
            @(negedge i_clk) push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        push             <= 1'b1;
        i_func           <= f;
        i_file_number    <= fd;
        i_buffer_address <= a;
        i_byte_limit     <= l;
        i_char_in        <= c;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        ign = f && !line_busy;
        edit_line(f, fd, a, l, c);
        case (chk)
            CHK_MODEL: foreach (step_results[i]) pending_results.push_back(step_results[i]);
            CHK_DONE: begin
                r.kind   = KIND_DONE;
                r.data   = CH_NUL;
                r.addr   = '0;
                r.status = st;
                r.count  = cnt;
                r.last   = 1'b1;
                pending_results.push_back(r);
            end
            default: ;
        endcase
        if (!ign) items_taken++;
    endtask

    // one register write over apb followed by a read back
    task automatic set_window(input t_reg idx, input logic [31:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge i_clk) penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_WINDOW_BASE) win_base = v;
        else win_limit = v;
        @(negedge i_clk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(negedge i_clk) penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        check_field("prdata", v, prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // random read requests, mostly well formed, with noise between them
    task automatic run_lines(input int target);
        int          sent;
        int          q;
        int          nchar;
        logic [7:0]  fd;
        logic [31:0] a;
        logic [31:0] l;
        longint      span;
        bit          ign;
        sent = 0;
        while (sent < target) begin
            q = $urandom_range(0, 99);
            if (q < 10) begin
                send_item(1'($urandom_range(0, 1)), 8'($urandom), $urandom, $urandom,
                          8'($urandom), CHK_MODEL, ST_OK, '0, ign);
                if (!ign) sent++;
            end else begin
                fd = (q < 15) ? 8'($urandom_range(1, 255)) : 8'h00;
                q = $urandom_range(0, 99);
                if (q < 70) l = $urandom_range(1, 10);
                else if (q < 85) l = $urandom_range(11, 40);
                else if (q < 93) l = '0;
                else l = $urandom;
                if (win_base <= win_limit) begin
                    // place the buffer mostly inside the window, touching its edges now and then
                    if (l > win_limit - win_base) l = win_limit - win_base;
                    span = longint'(win_limit) - longint'(win_base) - longint'(l);
                    q = $urandom_range(0, 9);
                    if (q == 0) a = win_base;
                    else if (q == 1) a = 32'(longint'(win_base) + span);
                    else if (q == 2) a = $urandom;
                    else a = 32'(longint'(win_base) + (longint'($urandom) % (span + 1)));
                end else begin
                    a = $urandom;
                end
                send_item(1'b0, fd, a, l, 8'($urandom), CHK_MODEL, ST_OK, '0, ign);
                sent++;
                nchar = $urandom_range(0, (l < 12) ? int'(l) + 4 : 16);
                for (int k = 0; k < nchar; k++) begin
                    if (!line_busy && $urandom_range(0, 3) != 0) break;
                    send_item(1'b1, 8'($urandom), $urandom, $urandom, pick_char(),
                              CHK_MODEL, ST_OK, '0, ign);
                    if (!ign) sent++;
                end
            end
        end
        @(negedge i_clk) push <= 1'b0;
    endtask

    // result side: random stalls, each popped item checked against the oldest expectation
    initial begin
        int      gap;
        t_result e;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = draw_gap(pop_run);
            if (gap > 0) begin
                @(negedge i_clk) pop <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk) pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got kind %0d byte %h addr %h",
                         $time, o_kind, o_out_byte, o_store_address);
            end else begin
                e = pending_results.pop_front();
                check_field("kind", 32'(e.kind), 32'(o_kind));
                check_field("out_byte", 32'(e.data), 32'(o_out_byte));
                check_field("store_address", e.addr, o_store_address);
                check_field("status", 32'(e.status), 32'(o_status));
                check_field("byte_count", e.count, o_byte_count);
                check_field("last", 32'(e.last), 32'(o_last));
            end
        end
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // main sequence
    initial begin
        bit ign;
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows under the reset window
        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].func, dir_rows[i].fd, dir_rows[i].addr, dir_rows[i].lim,
                      dir_rows[i].chr, dir_rows[i].chk, dir_rows[i].st, dir_rows[i].cnt, ign);
        end
        run_lines(PHASE_ITEMS);

        // remaining window settings, written only once the block has gone quiet
        for (int p = 1; p < N_PHASES; p++) begin
            wait_drained();
            set_window(REG_WINDOW_BASE, PH_BASE[p]);
            set_window(REG_WINDOW_LIMIT, PH_LIMIT[p]);
            run_lines(PHASE_ITEMS);
        end
        wait_drained();

        $display("%0d items taken over %0d window settings, %0d results checked",
                 items_taken, N_PHASES, results_seen);
        $display("%0d mismatches", errors);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> line_edit_receiver_top.f
rtl/core/ler_pkg.sv
rtl/core/ler_front.sv
rtl/core/ler_cmd_fifo.sv
rtl/core/ler_back.sv
rtl/core/line_edit_receiver_top.sv
bench/line_edit_receiver_top_tb.sv
